[src/sce_pkg.sv]
// Shared constants and types for the simplex coboundary enumerator.
package sce_pkg;

  localparam int MaxVertices  = 64;
  localparam int MaxDimension = 6;

  // Binomial table geometry: rows j = 0..MaxVertices, columns k = 0..MaxDimension+2.
  localparam int TabRows  = MaxVertices + 1;
  localparam int TabCols  = MaxDimension + 3;
  localparam int RowW     = $clog2(TabRows);
  localparam int ColW     = $clog2(TabCols);
  localparam int AddrW    = RowW + ColW;
  localparam int TabDepth = TabRows * (2 ** ColW);

  localparam int RankW   = 33;
  localparam int InRankW = 30;
  localparam int DimW    = 3;
  localparam int VcW     = 7;
  localparam int CursorW = RowW + 1;
  localparam int CountW  = $clog2(MaxVertices);
  localparam int InDataW = 40;
  localparam int OutDataW = 40;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 7;
  localparam logic [CfgIdxW-1:0] CfgVertexCount = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgAboveOnly   = 2'd1;

  typedef struct packed {
    logic [VcW-1:0] vertex_count;
    logic           above_only;
  } cfg_t;

  typedef struct packed {
    logic [AddrW-1:0] addr_a;
    logic [AddrW-1:0] addr_b;
  } tab_req_t;

endpackage

[src/simplex_coboundary_enumerator.sv]
// Top level of the simplex coboundary enumerator: config registers and stream ports.
//
// Usage: write vertex_count (index 0) and above_only_mode (index 1) on the cfg
// channel while the block is idle; cfg_ready_o is always high. Send one simplex
// per item on s_axis (colex rank and dimension). For each item the block
// returns its cofacet ranks on m_axis in descending order, tlast on the final
// one; if there is no cofacet a single item with tuser (empty) set and rank 0
// is returned instead.
// Timing: one item at a time. An item goes through the range check, then the cursor
// walk with one table lookup per step of j plus one per step that drops a vertex,
// then one push per result; each lookup has a read state and an evaluate state,
// as the binomial memory has a registered read port.
// s_axis_tready is low while an item is in progress.
// Reset: vertex_count returns to 64 and above_only_mode to 0; the binomial
// memory is then rebuilt row by row, during which s_axis_tready stays low
// (cfg writes are still taken).
// Stall: m_axis has an output register plus one held result; when the sink
// holds tready low the walk pauses and no result is lost.
module simplex_coboundary_enumerator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sce_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [sce_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [sce_pkg::InDataW-1:0]       s_axis_tdata,  // simplex_rank, dimension
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [sce_pkg::OutDataW-1:0]      m_axis_tdata,  // cofacet_rank
  output logic                              m_axis_tuser,  // is_empty
  output logic                              m_axis_tlast
);

  logic [sce_pkg::VcW-1:0]  vc_q, vc_d;
  logic                     mode_q, mode_d;
  sce_pkg::cfg_t            cfg;
  sce_pkg::tab_req_t        tab_req;
  logic [sce_pkg::RankW-1:0] tab_a;
  logic [sce_pkg::RankW-1:0] tab_b;
  logic                     tab_ready;
  logic [sce_pkg::RankW-1:0] out_rank;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    vc_d   = vc_q;
    mode_d = mode_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sce_pkg::CfgVertexCount: vc_d   = cfg_data_i[sce_pkg::VcW-1:0];
        sce_pkg::CfgAboveOnly:   mode_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q   <= sce_pkg::VcW'(sce_pkg::MaxVertices);
      mode_q <= 1'b0;
    end else begin
      vc_q   <= vc_d;
      mode_q <= mode_d;
    end
  end

  assign cfg.vertex_count = vc_q;
  assign cfg.above_only   = mode_q;

  sce_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (tab_req),
    .data_a_o (tab_a),
    .data_b_o (tab_b),
    .ready_o  (tab_ready)
  );

  sce_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .tab_ready_i (tab_ready),
    .tab_req_o   (tab_req),
    .tab_a_i     (tab_a),
    .tab_b_i     (tab_b),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_rank_i   (s_axis_tdata[sce_pkg::InRankW-1:0]),
    .in_dim_i    (s_axis_tdata[sce_pkg::InRankW +: sce_pkg::DimW]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_rank_o  (out_rank),
    .out_empty_o (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = sce_pkg::OutDataW'(out_rank);

endmodule

[src/sce_table.sv]
// Binomial coefficient memory, filled by a Pascal-row sweep after reset.
module sce_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sce_pkg::tab_req_t req_i,
  output logic [sce_pkg::RankW-1:0] data_a_o,
  output logic [sce_pkg::RankW-1:0] data_b_o,
  output logic              ready_o
);

  logic [sce_pkg::RankW-1:0] mem [sce_pkg::TabDepth];

  logic                        filling_q, filling_d;
  logic [sce_pkg::RowW-1:0]    fj_q, fj_d;
  logic [sce_pkg::ColW-1:0]    fk_q, fk_d;
  // previous row as a rotating shift line; top two taps hold C(j-1,k) and C(j-1,k-1)
  logic [sce_pkg::RankW-1:0]   row_q [sce_pkg::TabCols];
  logic [sce_pkg::RankW-1:0]   new_val;
  logic [sce_pkg::AddrW-1:0]   waddr;

  always_comb begin
    if (fk_q == '0) begin
      new_val = sce_pkg::RankW'(1);
    end else if (fj_q == '0) begin
      new_val = '0;
    end else begin
      new_val = row_q[sce_pkg::TabCols-1] + row_q[sce_pkg::TabCols-2];
    end
  end

  assign waddr = {fj_q, fk_q};

  always_comb begin
    filling_d = filling_q;
    fj_d      = fj_q;
    fk_d      = fk_q;
    if (filling_q) begin
      if (fk_q == '0) begin
        fk_d = sce_pkg::ColW'(sce_pkg::TabCols - 1);
        if (fj_q == sce_pkg::RowW'(sce_pkg::TabRows - 1)) begin
          filling_d = 1'b0;
        end else begin
          fj_d = fj_q + 1'b1;
        end
      end else begin
        fk_d = fk_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filling_q <= 1'b1;
      fj_q      <= '0;
      fk_q      <= sce_pkg::ColW'(sce_pkg::TabCols - 1);
    end else begin
      filling_q <= filling_d;
      fj_q      <= fj_d;
      fk_q      <= fk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (filling_q) begin
      row_q[0] <= new_val;
      for (int i = 1; i < sce_pkg::TabCols; i++) begin
        row_q[i] <= row_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (filling_q) begin
      mem[waddr] <= new_val;
    end
  end

  always_ff @(posedge clk_i) begin
    data_a_o <= mem[req_i.addr_a];
    data_b_o <= mem[req_i.addr_b];
  end

  assign ready_o = !filling_q;

endmodule

[src/sce_walk.sv]
// Cursor walk sequencer: steps j/k through the table and emits cofacet ranks.
module sce_walk (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sce_pkg::cfg_t                 cfg_i,
  input  logic                          tab_ready_i,
  output sce_pkg::tab_req_t             tab_req_o,
  input  logic [sce_pkg::RankW-1:0]     tab_a_i,
  input  logic [sce_pkg::RankW-1:0]     tab_b_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sce_pkg::InRankW-1:0]   in_rank_i,
  input  logic [sce_pkg::DimW-1:0]      in_dim_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sce_pkg::RankW-1:0]     out_rank_o,
  output logic                          out_empty_o,
  output logic                          out_last_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StChk  = 3'd1;
  localparam logic [2:0] StORd  = 3'd2;
  localparam logic [2:0] StOEv  = 3'd3;
  localparam logic [2:0] StIRd  = 3'd4;
  localparam logic [2:0] StIEv  = 3'd5;
  localparam logic [2:0] StPush = 3'd6;
  localparam logic [2:0] StDone = 3'd7;

  logic [2:0] state_q, state_d;

  logic [sce_pkg::RankW-1:0]   below_q, below_d;
  logic [sce_pkg::RankW-1:0]   above_q, above_d;
  logic [sce_pkg::RankW-1:0]   sum_q, sum_d;
  logic [sce_pkg::CursorW-1:0] j_q, j_d;   // two's complement, may reach -1
  logic [sce_pkg::ColW-1:0]    k_q, k_d;
  logic [sce_pkg::CountW-1:0]  cnt_q, cnt_d;
  logic [sce_pkg::RowW-1:0]    n_q, n_d;

  logic [sce_pkg::RankW-1:0]   pend_q, pend_d;
  logic                        pend_v_q, pend_v_d;

  logic                        ov_q, ov_d;
  logic [sce_pkg::RankW-1:0]   orank_q, orank_d;
  logic                        oempty_q, oempty_d;
  logic                        olast_q, olast_d;

  logic [sce_pkg::RowW-1:0]    n_sat;
  logic [sce_pkg::ColW-1:0]    in_k;
  logic                        accept;
  logic                        out_free;
  logic                        j_neg;
  logic                        j_ge_k;
  logic                        le;

  assign n_sat = (cfg_i.vertex_count > sce_pkg::VcW'(sce_pkg::MaxVertices))
               ? sce_pkg::RowW'(sce_pkg::MaxVertices)
               : sce_pkg::RowW'(cfg_i.vertex_count);
  assign in_k     = sce_pkg::ColW'(in_dim_i) + 1'b1;
  assign in_ready_o = (state_q == StIdle) && tab_ready_i;
  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !ov_q || out_ready_i;
  assign j_neg    = j_q[sce_pkg::CursorW-1];
  assign j_ge_k   = !j_neg && (j_q[sce_pkg::CursorW-2:0] >= sce_pkg::RowW'(k_q));
  assign le       = tab_a_i <= below_q;

  always_comb begin
    if (state_q == StIdle) begin
      tab_req_o.addr_a = {n_sat, in_k};
    end else begin
      tab_req_o.addr_a = {j_q[sce_pkg::CursorW-2:0], k_q};
    end
    tab_req_o.addr_b = {j_q[sce_pkg::CursorW-2:0], k_q + 1'b1};
  end

  always_comb begin
    state_d  = state_q;
    below_d  = below_q;
    above_d  = above_q;
    sum_d    = sum_q;
    j_d      = j_q;
    k_d      = k_q;
    cnt_d    = cnt_q;
    n_d      = n_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    ov_d     = ov_q && !out_ready_i;
    orank_d  = orank_q;
    oempty_d = oempty_q;
    olast_d  = olast_q;

    unique case (state_q) inside
      StIdle: begin
        if (accept) begin
          below_d = sce_pkg::RankW'(in_rank_i);
          k_d     = in_k;
          n_d     = n_sat;
          cnt_d   = '0;
          if (in_dim_i > sce_pkg::DimW'(sce_pkg::MaxDimension)) begin
            state_d = StDone;
          end else begin
            state_d = StChk;
          end
        end
      end
      StChk: begin
        // rank must lie below C(n, dim+1)
        if (below_q < tab_a_i) begin
          above_d = '0;
          j_d     = sce_pkg::CursorW'(n_q) - 1'b1;
          state_d = StORd;
        end else begin
          state_d = StDone;
        end
      end
      StORd, StIRd: begin
        if (state_q == StIRd) begin
          state_d = StIEv;
        end else if (j_ge_k && (cnt_q != '1)) begin
          state_d = StOEv;
        end else begin
          state_d = StDone;
        end
      end
      StOEv, StIEv: begin
        if (state_q == StOEv && cfg_i.above_only && le) begin
          state_d = StDone;
        end else if ((k_q != '0) && j_ge_k && le) begin
          below_d = below_q - tab_a_i;
          above_d = above_q + tab_b_i;
          j_d     = j_q - 1'b1;
          k_d     = k_q - 1'b1;
          state_d = StIRd;
        end else if (!j_ge_k) begin
          state_d = StDone;
        end else begin
          sum_d   = above_q + tab_b_i + below_q;
          j_d     = j_q - 1'b1;
          state_d = StPush;
        end
      end
      StPush: begin
        // newest rank is held back until we know whether it is the last
        if (!pend_v_q) begin
          pend_d   = sum_q;
          pend_v_d = 1'b1;
          cnt_d    = cnt_q + 1'b1;
          state_d  = StORd;
        end else if (out_free) begin
          ov_d     = 1'b1;
          orank_d  = pend_q;
          oempty_d = 1'b0;
          olast_d  = 1'b0;
          pend_d   = sum_q;
          cnt_d    = cnt_q + 1'b1;
          state_d  = StORd;
        end
      end
      StDone: begin
        if (out_free) begin
          ov_d     = 1'b1;
          orank_d  = pend_v_q ? pend_q : '0;
          oempty_d = !pend_v_q;
          olast_d  = 1'b1;
          pend_v_d = 1'b0;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      pend_v_q <= 1'b0;
      ov_q     <= 1'b0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      pend_v_q <= pend_v_d;
      ov_q     <= ov_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    below_q  <= below_d;
    above_q  <= above_d;
    sum_q    <= sum_d;
    j_q      <= j_d;
    k_q      <= k_d;
    n_q      <= n_d;
    pend_q   <= pend_d;
    orank_q  <= orank_d;
    oempty_q <= oempty_d;
    olast_q  <= olast_d;
  end

  assign out_valid_o = ov_q;
  assign out_rank_o  = orank_q;
  assign out_empty_o = oempty_q;
  assign out_last_o  = olast_q;

endmodule
